### sv/window_table_hit_test_top_defines.svh
// assertion helpers shared by the rtl
`ifndef WINDOW_TABLE_HIT_TEST_TOP_DEFINES_SVH
`define WINDOW_TABLE_HIT_TEST_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked only while reset is released
`define WHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("window table assertion failed");

// checked at every edge, reset included
`define WHT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("window table assertion failed");

`else

`define WHT_ASSERT(lbl, clk, rst_n, prop)
`define WHT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### sv/wht_pkg.sv
package wht_pkg;

    // table size default
    localparam int WHT_MAX_WINDOWS = 16;

    // commands
    localparam logic [1:0] CMD_UPSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_HIT    = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;
    localparam logic [2:0] ST_HIT      = 3'd5;
    localparam logic [2:0] ST_MISS     = 3'd6;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        app_id;
        logic signed [15:0] box_left;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic signed [15:0] box_top;
        logic [15:0]        depth_in;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        hit_app_id;
        logic signed [15:0] hit_left;
        logic signed [15:0] hit_right;
        logic signed [15:0] hit_bottom;
        logic signed [15:0] hit_top;
        logic [15:0]        hit_depth;
        logic [4:0]         window_count;
    } out_item_t;

    // one table entry
    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic signed [15:0] top;
        logic [15:0]        depth;
    } entry_t;

    // command token walking down the cell row
    typedef struct packed {
        logic               valid;
        logic [1:0]         cmd;
        entry_t             win;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               found;
        logic               placed;
    } token_t;

endpackage

### sv/window_table_hit_test_top.sv
// an accepted item's token walks the cell row, registered in every cell, is captured in tail_reg and then
// moves to the output register, where it waits while m_ready is low; only one item is in the row at a time
// the next item is taken once the result has moved to the output register
// reset: synchronous active-low aresetn empties the table and clears all valid flags
// table entries themselves are not cleared; only slots below the count take part in matches and hit tests
`include "window_table_hit_test_top_defines.svh"

module window_table_hit_test_top import wht_pkg::*; #(
    parameter int MAX_WINDOWS = WHT_MAX_WINDOWS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

    token_t                 tok_chain [MAX_WINDOWS+1];
    entry_t                 cell_entry [MAX_WINDOWS];
    logic [MAX_WINDOWS-1:0] chain_valid;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    token_t           tail_reg, tail_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;
    out_item_t        result;
    logic             accept;
    token_t           last_tok;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && !busy_reg;

    // build the token for cell 0
    always_comb begin
        tok_chain[0].valid      = accept;
        tok_chain[0].cmd        = s_item.command;
        tok_chain[0].win.id     = s_item.app_id;
        tok_chain[0].win.left   = s_item.box_left;
        tok_chain[0].win.right  = s_item.box_right;
        tok_chain[0].win.bottom = s_item.box_bottom;
        tok_chain[0].win.top    = s_item.box_top;
        tok_chain[0].win.depth  = s_item.depth_in;
        tok_chain[0].px         = s_item.point_x;
        tok_chain[0].py         = s_item.point_y;
        tok_chain[0].found      = 1'b0;
        tok_chain[0].placed     = 1'b0;
    end

    // row of table cells
    for (genvar g = 0; g < MAX_WINDOWS; g++) begin : g_cell
        entry_t nbr;
        if (g == MAX_WINDOWS - 1) begin : g_last
            assign nbr = cell_entry[g];
        end else begin : g_mid
            assign nbr = cell_entry[g+1];
        end
        wht_cell #(
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tok_in     (tok_chain[g]),
            .count      (count_reg),
            .next_entry (nbr),
            .entry      (cell_entry[g]),
            .tok_out    (tok_chain[g+1])
        );
        assign chain_valid[g] = tok_chain[g+1].valid;
    end

    assign last_tok = tok_chain[MAX_WINDOWS];

    // result from the finished token
    always_comb begin
        result              = '0;
        result.window_count = 5'(count_reg);
        case (tail_reg.cmd)
            CMD_UPSERT: begin
                result.status = tail_reg.found ? ST_UPDATED :
                                (tail_reg.placed ? ST_INSERTED : ST_FULL);
            end
            CMD_REMOVE: begin
                result.status = tail_reg.found ? ST_REMOVED : ST_ABSENT;
            end
            CMD_HIT: begin
                if (tail_reg.found) begin
                    result.status     = ST_HIT;
                    result.hit_app_id = tail_reg.win.id;
                    result.hit_left   = tail_reg.win.left;
                    result.hit_right  = tail_reg.win.right;
                    result.hit_bottom = tail_reg.win.bottom;
                    result.hit_top    = tail_reg.win.top;
                    result.hit_depth  = tail_reg.win.depth;
                end else begin
                    result.status = ST_MISS;
                end
            end
            default: begin
                result.status = ST_MISS;
            end
        endcase
    end

    // control: accept, capture at the end of the row, hand to output
    always_comb begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        tail_next    = tail_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (accept) begin
            busy_next = 1'b1;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (tail_reg.valid && (!m_valid_reg || m_ready)) begin
            m_valid_next    = 1'b1;
            m_item_next     = result;
            tail_next.valid = 1'b0;
            busy_next       = 1'b0;
        end
        if (last_tok.valid) begin
            tail_next = last_tok;
            if (last_tok.cmd == CMD_UPSERT && !last_tok.found && last_tok.placed) begin
                count_next = count_reg + CNT_W'(1);
            end else if (last_tok.cmd == CMD_REMOVE && last_tok.found) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            tail_reg.valid <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // checks
    `WHT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_WINDOWS))
    `WHT_ASSERT(a_one_in_flight, aclk, aresetn, $onehot0({tail_reg.valid, chain_valid}))
    `WHT_ASSERT(a_busy_while_walking, aclk, aresetn, (|chain_valid) |-> busy_reg)
    `WHT_ASSERT(a_count_step, aclk, aresetn, $past(aresetn) |-> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1) || count_reg == $past(count_reg) - CNT_W'(1)))
    `WHT_ASSERT_ALWAYS(a_result_source, aclk, (aresetn && $past(aresetn) && $rose(m_valid_reg)) |-> $past(tail_reg.valid))

endmodule

### sv/wht_cell.sv
module wht_cell import wht_pkg::*; #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  token_t           tok_in,
    input  logic [CNT_W-1:0] count,
    input  entry_t           next_entry,
    output entry_t           entry,
    output token_t           tok_out
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    entry_t entry_reg, entry_next;
    token_t tok_reg, tok_next;
    logic   in_range;
    logic   at_tail;
    logic   id_match;
    logic   inside_pt;

    assign in_range  = MY_IDX < count;
    assign at_tail   = MY_IDX == count;
    assign id_match  = in_range && (entry_reg.id == tok_in.win.id);
    assign inside_pt = in_range &&
                       (entry_reg.left < tok_in.px) && (entry_reg.bottom < tok_in.py) &&
                       (entry_reg.right > tok_in.px) && (entry_reg.top > tok_in.py);

    // act on the token as it passes this slot
    always_comb begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        if (tok_in.valid) begin
            case (tok_in.cmd)
                CMD_UPSERT: begin
                    if (!tok_in.found && id_match) begin
                        entry_next.left   = tok_in.win.left;
                        entry_next.right  = tok_in.win.right;
                        entry_next.bottom = tok_in.win.bottom;
                        entry_next.top    = tok_in.win.top;
                        entry_next.depth  = tok_in.win.depth;
                        tok_next.found    = 1'b1;
                    end else if (!tok_in.found && at_tail) begin
                        entry_next      = tok_in.win;
                        tok_next.placed = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    // close the gap: take the neighbor's entry from the match on
                    if (tok_in.found || id_match) begin
                        entry_next     = next_entry;
                        tok_next.found = 1'b1;
                    end
                end
                CMD_HIT: begin
                    // later entry wins on equal depth
                    if (inside_pt && (!tok_in.found || entry_reg.depth <= tok_in.win.depth)) begin
                        tok_next.win   = entry_reg;
                        tok_next.found = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;

endmodule
